// ===== sv/stt_pkg.sv =====
// Types, constants and helper functions shared by the source text tokenizer files.
// Depends on nothing; every other file of the block but stt_byte_if refers to it by scoped names.
`default_nettype none

package stt_pkg;

  // Width of the offsets carried on the result channel.
  localparam int unsigned OffW = 17;
  typedef logic [OffW-1:0] off_t;

  // Result queue geometry.
  localparam int unsigned FifoDepth = 8;
  localparam int unsigned PtrW      = 3;
  localparam int unsigned CntW      = 4;
  // Room for the largest burst that one byte can cause.
  localparam int unsigned MaxBurst  = 3;

  typedef enum logic [3:0] {
    KIND_PLUS      = 4'd0,
    KIND_SEMI      = 4'd1,
    KIND_EQ        = 4'd2,
    KIND_LPAREN    = 4'd3,
    KIND_RPAREN    = 4'd4,
    KIND_COLON     = 4'd5,
    KIND_NUMBER    = 4'd6,
    KIND_IDENT     = 4'd7,
    KIND_PRINT     = 4'd8,
    KIND_LET       = 4'd9,
    KIND_INT       = 4'd10,
    KIND_FLOAT     = 4'd11,
    KIND_ERROR     = 4'd12,
    KIND_EOF       = 4'd13,
    KIND_LINESTART = 4'd14
  } token_kind_e;

  typedef enum logic [2:0] {
    MODE_IDLE = 3'b001,
    MODE_NUM  = 3'b010,
    MODE_WORD = 3'b100
  } scan_mode_e;

  typedef struct packed {
    token_kind_e kind;
    off_t        start_off;
    off_t        end_off;
    logic        last;
  } token_t;

  localparam logic [7:0] CHAR_PLUS   = 8'h2B;
  localparam logic [7:0] CHAR_SEMI   = 8'h3B;
  localparam logic [7:0] CHAR_EQ     = 8'h3D;
  localparam logic [7:0] CHAR_LPAREN = 8'h28;
  localparam logic [7:0] CHAR_RPAREN = 8'h29;
  localparam logic [7:0] CHAR_COLON  = 8'h3A;
  localparam logic [7:0] CHAR_NL     = 8'h0A;
  localparam logic [7:0] CHAR_SPACE  = 8'h20;
  localparam logic [7:0] CHAR_TAB    = 8'h09;
  localparam logic [7:0] CHAR_CR     = 8'h0D;
  localparam logic [7:0] CHAR_FF     = 8'h0C;

  // Keywords packed with the earliest letter in the highest byte.
  localparam logic [39:0] WORD_PRINT = 40'h7072696E74;
  localparam logic [39:0] WORD_FLOAT = 40'h666C6F6174;
  localparam logic [39:0] WORD_LET   = 40'h00006C6574;
  localparam logic [39:0] WORD_INT   = 40'h0000696E74;

  // Classifies a finished word from its first five letters and its length.
  function automatic token_kind_e word_kind(logic [39:0] prefix, logic [2:0] count);
    if (count == 3'd5 && prefix == WORD_PRINT) return KIND_PRINT;
    if (count == 3'd5 && prefix == WORD_FLOAT) return KIND_FLOAT;
    if (count == 3'd3 && prefix == WORD_LET)   return KIND_LET;
    if (count == 3'd3 && prefix == WORD_INT)   return KIND_INT;
    return KIND_IDENT;
  endfunction

endpackage

`default_nettype wire

// ===== sv/stt_byte_if.sv =====
// Valid/ready channel that carries one byte of source text per request.
// Depends on nothing.
`default_nettype none

interface stt_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       final_char;

  modport source (output valid, char_code, final_char, input ready);
  modport sink (input valid, char_code, final_char, output ready);
endinterface

`default_nettype wire

// ===== sv/stt_token_if.sv =====
// Valid/ready channel that carries one token record per request.
// Depends on stt_pkg for the offset width.
`default_nettype none

interface stt_token_if;
  logic                     valid;
  logic                     ready;
  logic [3:0]               token_kind;
  logic [stt_pkg::OffW-1:0] start_offset;
  logic [stt_pkg::OffW-1:0] end_offset;
  logic                     run_last;

  modport source (output valid, token_kind, start_offset, end_offset, run_last, input ready);
  modport sink (input valid, token_kind, start_offset, end_offset, run_last, output ready);
endinterface

`default_nettype wire

// ===== sv/source_text_tokenizer_core.sv =====
// Top level of the source text tokenizer: byte classifier, scan state and result queue.
// Depends on stt_pkg, stt_byte_if and stt_token_if.
//
// Usage: source text enters on byte_i, one byte per request, with final_char set on
// the last byte of a source. Tokens leave on token_o as kind, start offset and end
// offset; run_last marks the last token caused by one byte. A byte causes zero to
// three tokens: the close of a pending number or word, its own token, and on the
// final byte the close of a token still open plus the end-of-file token.
// Every token of a byte is registered into the result queue when the byte is
// accepted, and is offered on token_o once the tokens queued ahead of it are taken.
// Throughput: one byte per cycle while token_o is not stalled and bytes cause at
// most one token each. The result queue holds eight tokens and byte_i.ready is high
// while at least three entries are free, so bursts are absorbed and the rate is set
// by the queue drain. A stall on token_o holds the head token stable; the input keeps
// flowing until fewer than three queue entries are free.
// Reset clears the scan state to idle at offset zero and empties the queue. After
// a final byte the scan state returns to the same values, so the next byte starts a
// new source at offset zero. Positions saturate at MAX_SOURCE_BYTES.
`default_nettype none

module source_text_tokenizer_core #(
  parameter int unsigned MAX_SOURCE_BYTES = 65536
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  stt_byte_if.sink    byte_i,
  stt_token_if.source token_o
);

  localparam int unsigned PosW = $clog2(MAX_SOURCE_BYTES + 1);
  localparam logic [PosW-1:0] PosMax = PosW'(MAX_SOURCE_BYTES);
  localparam logic [stt_pkg::CntW-1:0] ReadyLimit =
    stt_pkg::CntW'(stt_pkg::FifoDepth - stt_pkg::MaxBurst);

  // Scan state.
  stt_pkg::scan_mode_e mode_q, mode_d;
  logic [PosW-1:0]     pos_q, pos_d;
  logic [PosW-1:0]     tb_q, tb_d;
  logic [39:0]         prefix_q, prefix_d;
  logic [2:0]          count_q, count_d;

  // Result queue.
  stt_pkg::token_t             fifo_q [stt_pkg::FifoDepth];
  logic [stt_pkg::PtrW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [stt_pkg::CntW-1:0]    fill_q;

  logic                  accept, pop;
  logic [7:0]            c;
  logic                  fin;
  logic [PosW-1:0]       pos_nx;
  stt_pkg::off_t         p_off, nx_off;
  logic                  is_digit, is_alpha, is_ws, is_nl;
  logic                  punct_v;
  stt_pkg::token_kind_e  punct_kind;

  logic                  taken;
  stt_pkg::scan_mode_e   mid_mode;
  logic [PosW-1:0]       mid_tb;
  logic [39:0]           mid_prefix;
  logic [2:0]            mid_count;

  // Candidate tokens in output order: pending close, own token, final close, eof.
  stt_pkg::token_t       cand [4];
  logic [3:0]            cand_v;
  logic [3:0]            cand_last;
  logic [stt_pkg::PtrW-1:0] wr_idx [4];
  logic [1:0]            push_n;

  assign accept = byte_i.valid && byte_i.ready;
  assign pop    = token_o.valid && token_o.ready;
  assign byte_i.ready = (fill_q <= ReadyLimit);

  assign c   = byte_i.char_code;
  assign fin = byte_i.final_char;

  assign pos_nx = (pos_q == PosMax) ? PosMax : pos_q + PosW'(1);
  assign p_off  = stt_pkg::off_t'(pos_q);
  assign nx_off = stt_pkg::off_t'(pos_nx);

  assign is_digit = (c >= 8'h30) && (c <= 8'h39);
  assign is_alpha = ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  assign is_ws    = (c == stt_pkg::CHAR_SPACE) || (c == stt_pkg::CHAR_TAB) ||
                    (c == stt_pkg::CHAR_CR) || (c == stt_pkg::CHAR_FF);
  assign is_nl    = (c == stt_pkg::CHAR_NL);

  always_comb begin
    punct_v    = 1'b1;
    punct_kind = stt_pkg::KIND_ERROR;
    unique case (c)
      stt_pkg::CHAR_PLUS:   punct_kind = stt_pkg::KIND_PLUS;
      stt_pkg::CHAR_SEMI:   punct_kind = stt_pkg::KIND_SEMI;
      stt_pkg::CHAR_EQ:     punct_kind = stt_pkg::KIND_EQ;
      stt_pkg::CHAR_LPAREN: punct_kind = stt_pkg::KIND_LPAREN;
      stt_pkg::CHAR_RPAREN: punct_kind = stt_pkg::KIND_RPAREN;
      stt_pkg::CHAR_COLON:  punct_kind = stt_pkg::KIND_COLON;
      default:              punct_v    = 1'b0;
    endcase
  end

  // Per-byte scan: close or extend the pending token, then classify the byte.
  always_comb begin
    taken       = 1'b0;
    cand_v      = '0;
    cand[0]     = '{kind: stt_pkg::KIND_NUMBER, start_off: stt_pkg::off_t'(tb_q),
                    end_off: p_off, last: 1'b0};
    mid_mode    = mode_q;
    mid_tb      = tb_q;
    mid_prefix  = prefix_q;
    mid_count   = count_q;

    unique case (mode_q)
      stt_pkg::MODE_NUM: begin
        if (is_digit) begin
          taken = 1'b1;
        end else begin
          cand_v[0] = 1'b1;
          mid_mode  = stt_pkg::MODE_IDLE;
        end
      end
      stt_pkg::MODE_WORD: begin
        if (is_alpha || is_digit) begin
          taken = 1'b1;
          if (count_q < 3'd5) begin
            mid_prefix = {prefix_q[31:0], c};
          end
          if (count_q < 3'd6) begin
            mid_count = count_q + 3'd1;
          end
        end else begin
          cand_v[0]    = 1'b1;
          cand[0].kind = stt_pkg::word_kind(prefix_q, count_q);
          mid_mode     = stt_pkg::MODE_IDLE;
        end
      end
      default: mid_mode = stt_pkg::MODE_IDLE;
    endcase

    cand[1] = '{kind: stt_pkg::KIND_ERROR, start_off: p_off, end_off: nx_off, last: 1'b0};
    if (!taken) begin
      priority if (is_ws) begin
        cand_v[1] = 1'b0;
      end else if (is_nl) begin
        cand_v[1]         = 1'b1;
        cand[1].kind      = stt_pkg::KIND_LINESTART;
        cand[1].start_off = nx_off;
      end else if (punct_v) begin
        cand_v[1]    = 1'b1;
        cand[1].kind = punct_kind;
      end else if (is_digit) begin
        mid_mode = stt_pkg::MODE_NUM;
        mid_tb   = pos_q;
      end else if (is_alpha) begin
        mid_mode   = stt_pkg::MODE_WORD;
        mid_tb     = pos_q;
        mid_prefix = {32'h0, c};
        mid_count  = 3'd1;
      end else begin
        cand_v[1] = 1'b1;
      end
    end

    // The final byte closes whatever is still open and ends the source.
    cand_v[2] = fin && (mid_mode != stt_pkg::MODE_IDLE);
    cand[2]   = '{kind: (mid_mode == stt_pkg::MODE_NUM) ? stt_pkg::KIND_NUMBER
                        : stt_pkg::word_kind(mid_prefix, mid_count),
                  start_off: stt_pkg::off_t'(mid_tb), end_off: nx_off, last: 1'b0};
    cand_v[3] = fin;
    cand[3]   = '{kind: stt_pkg::KIND_EOF, start_off: nx_off, end_off: nx_off, last: 1'b0};

    if (fin) begin
      mode_d   = stt_pkg::MODE_IDLE;
      pos_d    = '0;
      tb_d     = '0;
      prefix_d = '0;
      count_d  = '0;
    end else begin
      mode_d   = mid_mode;
      pos_d    = pos_nx;
      tb_d     = mid_tb;
      prefix_d = mid_prefix;
      count_d  = mid_count;
    end
  end

  // Pack the valid candidates into consecutive queue slots and mark the last one.
  always_comb begin
    logic [1:0] slot;
    logic       later;
    slot  = '0;
    later = 1'b0;
    for (int i = 0; i < 4; i++) begin
      wr_idx[i] = wr_ptr_q + stt_pkg::PtrW'(slot);
      slot      = slot + 2'(cand_v[i]);
    end
    push_n = slot;
    for (int i = 3; i >= 0; i--) begin
      cand_last[i] = cand_v[i] && !later;
      later        = later || cand_v[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= stt_pkg::MODE_IDLE;
      pos_q    <= '0;
      tb_q     <= '0;
      prefix_q <= '0;
      count_q  <= '0;
    end else if (accept) begin
      mode_q   <= mode_d;
      pos_q    <= pos_d;
      tb_q     <= tb_d;
      prefix_q <= prefix_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (accept) begin
        wr_ptr_q <= wr_ptr_q + stt_pkg::PtrW'(push_n);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + stt_pkg::PtrW'(1);
      end
      fill_q <= fill_q + (accept ? stt_pkg::CntW'(push_n) : '0) -
                stt_pkg::CntW'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 4; i++) begin
      if (accept && cand_v[i]) begin
        fifo_q[wr_idx[i]] <= '{kind: cand[i].kind, start_off: cand[i].start_off,
                               end_off: cand[i].end_off, last: cand_last[i]};
      end
    end
  end

  assign token_o.valid        = (fill_q != '0);
  assign token_o.token_kind   = fifo_q[rd_ptr_q].kind;
  assign token_o.start_offset = fifo_q[rd_ptr_q].start_off;
  assign token_o.end_offset   = fifo_q[rd_ptr_q].end_off;
  assign token_o.run_last     = fifo_q[rd_ptr_q].last;

endmodule

`default_nettype wire

// ===== sv/stt_checker.sv =====
// Port-level checks for the source text tokenizer, bound to its top level.
// Depends on stt_pkg and source_text_tokenizer_core.
`default_nettype none

module stt_checker (
  input wire                     clk_i,
  input wire                     rst_ni,
  input wire                     in_ready_i,
  input wire                     out_valid_i,
  input wire                     out_ready_i,
  input wire [3:0]               token_kind_i,
  input wire [stt_pkg::OffW-1:0] start_offset_i,
  input wire [stt_pkg::OffW-1:0] end_offset_i,
  input wire                     run_last_i
);

  // A pending token stays offered until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("token request dropped before it was taken");

  // A stalled token keeps its payload.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(token_kind_i) && $stable(start_offset_i) &&
      $stable(end_offset_i) && $stable(run_last_i))
    else $error("stalled token payload changed");

  // Input back-pressure only comes from queued tokens.
  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i)
    else $error("byte input stalled with no token queued");

  // End-of-file is always the last token of its byte and has an empty span.
  a_eof_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (token_kind_i == stt_pkg::KIND_EOF) |->
      run_last_i && (start_offset_i == end_offset_i))
    else $error("end-of-file token malformed");

  // A line start record marks a point, not a span.
  a_linestart_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (token_kind_i == stt_pkg::KIND_LINESTART) |->
      (start_offset_i == end_offset_i))
    else $error("line start record has a nonempty span");

endmodule

bind source_text_tokenizer_core stt_checker u_stt_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_ready_i     (byte_i.ready),
  .out_valid_i    (token_o.valid),
  .out_ready_i    (token_o.ready),
  .token_kind_i   (token_o.token_kind),
  .start_offset_i (token_o.start_offset),
  .end_offset_i   (token_o.end_offset),
  .run_last_i     (token_o.run_last)
);

`default_nettype wire
